/* hw/rtl/thermal_frame_min_max_locator_core_macros.svh */
// assertion macros for the thermal frame min/max locator
`ifndef THERMAL_FRAME_MIN_MAX_LOCATOR_CORE_MACROS_SVH
`define THERMAL_FRAME_MIN_MAX_LOCATOR_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define TFML_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tfml check failed");

// next-cycle implication, disabled during reset
`define TFML_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tfml check failed");

`endif

/* hw/rtl/tfml_pkg.sv */
// shared types and constants for the thermal frame min/max locator
`default_nettype none

package tfml_pkg;

   localparam int unsigned PixW   = 16;
   localparam int unsigned CoordW = 16;
   localparam int unsigned CsrAddrW = 1;
   localparam int unsigned CsrDataW = 16;
   localparam int unsigned RspDataW = 2 * PixW + 4 * CoordW;

   // register indexes
   localparam logic [CsrAddrW-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CsrAddrW-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [15:0] FrameWidthReset  = 16'd640;
   localparam logic [15:0] FrameHeightReset = 16'd512;

   // 1/64 kelvin to centi-celsius
   localparam int unsigned ProdW = 23;
   localparam int unsigned QuotW = ProdW - 6;
   localparam logic [6:0]       RawScaleMul = 7'd100;
   localparam logic [5:0]       RawRound    = 6'd32;
   localparam logic [QuotW-1:0] KelvinOffset = 17'd27315;

   typedef struct packed {
      logic [15:0] width;
      logic [15:0] height;
   } geom_type;

   typedef struct packed {
      logic [PixW-1:0]   max_raw;
      logic [PixW-1:0]   min_raw;
      logic [CoordW-1:0] max_col;
      logic [CoordW-1:0] max_row;
      logic [CoordW-1:0] min_col;
      logic [CoordW-1:0] min_row;
   } stats_type;

   typedef struct packed {
      logic [15:0]       max_centi_c;
      logic [15:0]       min_centi_c;
      logic [CoordW-1:0] max_col;
      logic [CoordW-1:0] max_row;
      logic [CoordW-1:0] min_col;
      logic [CoordW-1:0] min_row;
   } result_type;

endpackage

`default_nettype wire

/* hw/rtl/tfml_tracker.sv */
// raster position tracking and running min/max with first-occurrence position
`default_nettype none

module tfml_tracker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire tfml_pkg::geom_type         geom,
   input  wire logic                       pix_valid,
   input  wire logic [tfml_pkg::PixW-1:0]  pix,
   output logic                            pix_take,
   output logic                            done_valid,
   input  wire logic                       done_ready,
   output tfml_pkg::stats_type             done_stats
);
   import tfml_pkg::*;

   logic [CoordW-1:0] cur_col_ff, cur_col_in;
   logic [CoordW-1:0] cur_row_ff, cur_row_in;
   stats_type         best_ff, best_in, best_upd;
   stats_type         done_ff;
   logic              done_vld_ff;
   logic [CoordW:0]   col_inc, row_inc;
   logic              first_pix, col_end, row_end, frame_end, done_free;

   assign col_inc   = {1'b0, cur_col_ff} + {{CoordW{1'b0}}, 1'b1};
   assign row_inc   = {1'b0, cur_row_ff} + {{CoordW{1'b0}}, 1'b1};
   // a zero register value ends the row or frame at once, as a size of one
   assign col_end   = col_inc >= {1'b0, geom.width};
   assign row_end   = row_inc >= {1'b0, geom.height};
   assign frame_end = col_end && row_end;
   assign first_pix = (cur_col_ff == '0) && (cur_row_ff == '0);

   assign done_free = !done_vld_ff || done_ready;
   assign pix_take  = pix_valid && (!frame_end || done_free);

   always_comb begin
      best_upd = best_ff;
      if (first_pix) begin
         best_upd.max_raw = pix;
         best_upd.min_raw = pix;
         best_upd.max_col = '0;
         best_upd.max_row = '0;
         best_upd.min_col = '0;
         best_upd.min_row = '0;
      end else begin
         if (pix < best_ff.min_raw) begin
            best_upd.min_raw = pix;
            best_upd.min_col = cur_col_ff;
            best_upd.min_row = cur_row_ff;
         end
         if (pix > best_ff.max_raw) begin
            best_upd.max_raw = pix;
            best_upd.max_col = cur_col_ff;
            best_upd.max_row = cur_row_ff;
         end
      end
   end

   always_comb begin
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      best_in    = best_ff;
      if (pix_take) begin
         if (!col_end) begin
            cur_col_in = col_inc[CoordW-1:0];
            best_in    = best_upd;
         end else if (!row_end) begin
            cur_col_in = '0;
            cur_row_in = row_inc[CoordW-1:0];
            best_in    = best_upd;
         end else begin
            cur_col_in = '0;
            cur_row_in = '0;
            best_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff  <= '0;
         cur_row_ff  <= '0;
         best_ff     <= '0;
         done_vld_ff <= 1'b0;
      end else begin
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
         best_ff    <= best_in;
         if (pix_take && frame_end) begin
            done_vld_ff <= 1'b1;
         end else if (done_ready) begin
            done_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pix_take && frame_end) begin
         done_ff <= best_upd;
      end
   end

   assign done_valid = done_vld_ff;
   assign done_stats = done_ff;

endmodule

`default_nettype wire

/* hw/rtl/tfml_convert.sv */
// raw to centi-celsius conversion with saturation and result register
`default_nettype none

module tfml_convert (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire tfml_pkg::stats_type  in_stats,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output tfml_pkg::result_type      out_result
);
   import tfml_pkg::*;

   function automatic logic [15:0] to_centi_c(input logic [PixW-1:0] raw);
      logic [ProdW-1:0] prod;
      logic [QuotW-1:0] quot;
      logic [QuotW-1:0] diff;
      prod = ({{(ProdW-PixW){1'b0}}, raw} * {{(ProdW-7){1'b0}}, RawScaleMul})
             + {{(ProdW-6){1'b0}}, RawRound};
      quot = prod[ProdW-1:6];
      diff = quot - KelvinOffset;
      if (quot < KelvinOffset) begin
         to_centi_c = 16'd0;
      end else if (diff[QuotW-1]) begin
         to_centi_c = 16'hffff;
      end else begin
         to_centi_c = diff[15:0];
      end
   endfunction

   result_type result_ff, result_in;
   logic       vld_ff;

   assign in_ready = !vld_ff || out_ready;

   always_comb begin
      result_in.max_centi_c = to_centi_c(in_stats.max_raw);
      result_in.min_centi_c = to_centi_c(in_stats.min_raw);
      result_in.max_col     = in_stats.max_col;
      result_in.max_row     = in_stats.max_row;
      result_in.min_col     = in_stats.min_col;
      result_in.min_row     = in_stats.min_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = vld_ff;
   assign out_result = result_ff;

endmodule

`default_nettype wire

/* hw/rtl/thermal_frame_min_max_locator_core.sv */
// top level of the thermal frame min/max locator
`default_nettype none

// Takes one 16-bit radiometric pixel (1/64 K) per beat in raster order and,
// after frame_width * frame_height pixels, returns one beat with the hottest
// and coldest values in centi-Celsius (saturated to 0..65535) and the column
// and row of the first occurrence of each. One pixel is accepted every clock;
// the only stall comes from a held result beat backing up the result
// register and the frame-done register. After the last pixel of its frame
// is accepted into the input register, its result passes through the tracker
// frame-done register, then the conversion register. Geometry writes take
// effect at once.
module thermal_frame_min_max_locator_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [15:0]                    req_tdata,   // pixel_raw
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // max_centi_c, min_centi_c, max_col, max_row, min_col, min_row
   output logic [tfml_pkg::RspDataW-1:0]       rsp_tdata,
   input  wire logic                           csr_we,
   input  wire logic [tfml_pkg::CsrAddrW-1:0]  csr_addr,
   input  wire logic [tfml_pkg::CsrDataW-1:0]  csr_wdata
);
   import tfml_pkg::*;

   geom_type        geom_ff;
   logic [PixW-1:0] pix_ff;
   logic            pix_vld_ff;
   logic            pix_take;
   logic            done_valid, done_ready;
   stats_type       done_stats;
   result_type      result;

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff.width  <= FrameWidthReset;
         geom_ff.height <= FrameHeightReset;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_FRAME_WIDTH:  geom_ff.width  <= csr_wdata;
            CSR_FRAME_HEIGHT: geom_ff.height <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = !pix_vld_ff || pix_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_vld_ff <= 1'b0;
      end else if (req_tready) begin
         pix_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         pix_ff <= req_tdata;
      end
   end

   tfml_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .geom       (geom_ff),
      .pix_valid  (pix_vld_ff),
      .pix        (pix_ff),
      .pix_take   (pix_take),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .done_stats (done_stats)
   );

   tfml_convert u_convert (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (done_valid),
      .in_ready   (done_ready),
      .in_stats   (done_stats),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {result.min_row, result.min_col, result.max_row,
                       result.max_col, result.min_centi_c,
                       result.max_centi_c};

endmodule

`default_nettype wire

/* hw/rtl/tfml_checker.sv */
// port-level checks for the thermal frame min/max locator, bound to the top
`default_nettype none

`include "thermal_frame_min_max_locator_core_macros.svh"

module tfml_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [95:0] rsp_tdata
);

   `TFML_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `TFML_ASSERT_NOW(a_ready_when_drained, clock, reset, !rsp_tvalid, req_tready)
   `TFML_ASSERT_NOW(a_min_not_above_max, clock, reset, rsp_tvalid, rsp_tdata[31:16] <= rsp_tdata[15:0])
   `TFML_ASSERT_NOW(a_coord_range, clock, reset, rsp_tvalid, (rsp_tdata[47:32] != 16'hffff) && (rsp_tdata[79:64] != 16'hffff))

endmodule

bind thermal_frame_min_max_locator_core tfml_checker u_tfml_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
